// ----- design/cprd_pkg.sv -----
// Package for the controller report port decode block.
// Holds the record and pad beat types, decode constants and helper functions.
// No dependencies.
package cprd_pkg;

  localparam int unsigned PortW      = 2;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned PadBtnW    = 13;
  localparam int unsigned OriginW    = 6 * ByteW;

  localparam logic [ByteW-1:0] StatusPresentMask = 8'h30;
  localparam logic signed [ByteW-1:0] AxisMax = 8'sh7F;
  localparam logic signed [ByteW-1:0] AxisMin = -8'sd128;

  typedef struct packed {
    logic [PortW-1:0] port;
    logic [ByteW-1:0] status_byte;
    logic [ByteW-1:0] buttons_low;
    logic [ByteW-1:0] buttons_high;
    logic [ByteW-1:0] main_x_raw;
    logic [ByteW-1:0] main_y_raw;
    logic [ByteW-1:0] c_x_raw;
    logic [ByteW-1:0] c_y_raw;
    logic [ByteW-1:0] left_trigger_raw;
    logic [ByteW-1:0] right_trigger_raw;
  } rec_t;

  typedef struct packed {
    logic                     connected;
    logic [PadBtnW-1:0]       pad_buttons;
    logic signed [ByteW-1:0]  main_x;
    logic signed [ByteW-1:0]  main_y;
    logic signed [ByteW-1:0]  c_x;
    logic signed [ByteW-1:0]  c_y;
    logic [ByteW-1:0]         left_trigger;
    logic [ByteW-1:0]         right_trigger;
  } pad_t;

  typedef struct packed {
    logic [ByteW-1:0] main_x;
    logic [ByteW-1:0] main_y;
    logic [ByteW-1:0] c_x;
    logic [ByteW-1:0] c_y;
    logic [ByteW-1:0] left_trigger;
    logic [ByteW-1:0] right_trigger;
  } origin_t;

  function automatic logic signed [ByteW-1:0] axis_rel(logic [ByteW-1:0] raw,
                                                       logic [ByteW-1:0] org);
    logic [ByteW:0] diff;
    logic signed [ByteW-1:0] res;
    diff = {1'b0, raw} - {1'b0, org};
    if (!diff[ByteW] && diff[ByteW-1]) begin
      res = AxisMax;
    end else if (diff[ByteW] && !diff[ByteW-1]) begin
      res = AxisMin;
    end else begin
      res = diff[ByteW-1:0];
    end
    return res;
  endfunction

  function automatic logic [ByteW-1:0] trig_rel(logic [ByteW-1:0] raw,
                                                logic [ByteW-1:0] org);
    return (raw > org) ? (raw - org) : '0;
  endfunction

  function automatic logic [PadBtnW-1:0] remap_buttons(logic [ByteW-1:0] lo,
                                                       logic [ByteW-1:0] hi);
    return {hi[0], lo[3:0], 1'b0, hi[3:1], lo[7:4]};
  endfunction

endpackage

// ----- design/cprd_if.sv -----
// Valid/ready channel interfaces for record beats in and pad beats out.
// Depends on cprd_pkg for the payload types.
interface cprd_rec_if
  import cprd_pkg::*;
();
  logic valid;
  logic ready;
  rec_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cprd_pad_if
  import cprd_pkg::*;
();
  logic valid;
  logic ready;
  pad_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/controller_report_port_decode_unit.sv -----
// Top level: decodes one port record per beat into a pad beat.
// Depends on cprd_pkg and the channel interfaces in cprd_if.sv.
//
// channel  dir  beat                 handshake
// rec_i    in   rec_t port record    valid/ready
// pad_o    out  pad_t decoded pad    valid/ready
//
// One record per cycle while pad_o is ready; path: input register, then result register.
// The per-port origin table is read and updated in the same cycle as the subtract and clamp.
// Reset clears the origin valid bits and both pipeline valids; origin bytes need no reset.
// A stall on pad_o holds the result register, then the input register, then drops rec_i.ready.
module controller_report_port_decode_unit
  import cprd_pkg::*;
#(
  parameter int unsigned NUM_PORTS = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cprd_rec_if.sink      rec_i,
  cprd_pad_if.source    pad_o
);

  localparam int unsigned Reach = 1 << PortW;
  localparam int unsigned Depth = (NUM_PORTS < Reach) ? NUM_PORTS : Reach;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic           s0_valid_q, s0_valid_d;
  rec_t           s0_q;
  logic           out_valid_q, out_valid_d;
  pad_t           out_q, out_d;
  logic [Depth-1:0] org_valid_q, org_valid_d;
  origin_t        org_mem [Depth];

  logic           s0_adv;
  logic           in_range;
  logic           present;
  logic [IdxW-1:0] idx;
  origin_t        raw_org;
  origin_t        org;
  logic           org_wr;

  assign s0_adv      = s0_valid_q && (!out_valid_q || pad_o.ready);
  assign rec_i.ready = !s0_valid_q || s0_adv;

  assign in_range = (32'(s0_q.port) < NUM_PORTS);
  assign present  = |(s0_q.status_byte & StatusPresentMask);
  assign idx      = IdxW'(s0_q.port);
  assign raw_org  = '{main_x:        s0_q.main_x_raw,
                      main_y:        s0_q.main_y_raw,
                      c_x:           s0_q.c_x_raw,
                      c_y:           s0_q.c_y_raw,
                      left_trigger:  s0_q.left_trigger_raw,
                      right_trigger: s0_q.right_trigger_raw};
  assign org      = org_valid_q[idx] ? org_mem[idx] : raw_org;
  assign org_wr   = s0_adv && in_range && present && !org_valid_q[idx];

  always_comb begin
    out_d       = '0;
    org_valid_d = org_valid_q;
    if (in_range && present) begin
      out_d.connected     = 1'b1;
      out_d.pad_buttons   = remap_buttons(s0_q.buttons_low, s0_q.buttons_high);
      out_d.main_x        = axis_rel(s0_q.main_x_raw, org.main_x);
      out_d.main_y        = axis_rel(s0_q.main_y_raw, org.main_y);
      out_d.c_x           = axis_rel(s0_q.c_x_raw, org.c_x);
      out_d.c_y           = axis_rel(s0_q.c_y_raw, org.c_y);
      out_d.left_trigger  = trig_rel(s0_q.left_trigger_raw, org.left_trigger);
      out_d.right_trigger = trig_rel(s0_q.right_trigger_raw, org.right_trigger);
    end
    if (s0_adv && in_range) begin
      org_valid_d[idx] = present;
    end
  end

  always_comb begin
    s0_valid_d = s0_valid_q;
    if (rec_i.ready) begin
      s0_valid_d = rec_i.valid;
    end
    out_valid_d = out_valid_q;
    if (s0_adv) begin
      out_valid_d = 1'b1;
    end else if (pad_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      org_valid_q <= '0;
    end else begin
      s0_valid_q  <= s0_valid_d;
      out_valid_q <= out_valid_d;
      org_valid_q <= org_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_i.valid && rec_i.ready) begin
      s0_q <= rec_i.data;
    end
    if (s0_adv) begin
      out_q <= out_d;
    end
    if (org_wr) begin
      org_mem[idx] <= raw_org;
    end
  end

  assign pad_o.valid = out_valid_q;
  assign pad_o.data  = out_q;

  a_disc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.connected |-> out_q.pad_buttons == '0 && out_q.main_x == '0
      && out_q.main_y == '0 && out_q.c_x == '0 && out_q.c_y == '0
      && out_q.left_trigger == '0 && out_q.right_trigger == '0)
    else $error("disconnected pad beat carries nonzero fields");

  a_org_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_adv && in_range && present |=> org_valid_q[$past(idx)])
    else $error("origin not marked valid after connected record");

  a_org_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_adv && in_range && !present |=> !org_valid_q[$past(idx)])
    else $error("origin kept after disconnected record");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid_q && !s0_adv |=> s0_valid_q && $stable(s0_q))
    else $error("input register lost a beat while stalled");

endmodule
